// ----- rtl/core/ang_pkg.sv -----
// ----------------------------------------------------------------------------
// ang_pkg
// Shared types, codes and the microcode table of the audio noise gate.
// ----------------------------------------------------------------------------
package ang_pkg;

    // gate phases
    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_ATTACK = 2'd1;
    localparam logic [1:0] PH_ACTIVE = 2'd2;
    localparam logic [1:0] PH_DECAY  = 2'd3;

    // register field widths
    localparam int THR_BITS      = 15;
    localparam int MS_BITS       = 11;
    localparam int SPM_BITS      = 8;
    localparam int LOAD_BITS     = MS_BITS + SPM_BITS;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_ATTACK_MS = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_HOLD_MS   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_DECAY_MS  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_SPM       = 3'd4;

    // register reset values
    localparam logic [THR_BITS-1:0] THRESHOLD_RST = 15'd1000;
    localparam logic [MS_BITS-1:0]  ATTACK_MS_RST = 11'd10;
    localparam logic [MS_BITS-1:0]  HOLD_MS_RST   = 11'd100;
    localparam logic [MS_BITS-1:0]  DECAY_MS_RST  = 11'd100;
    localparam logic [SPM_BITS-1:0] SPM_RST       = 8'd48;

    // Q16 ramp gain, one extra bit for unity
    localparam int Q_SHIFT   = 16;
    localparam int GAIN_BITS = Q_SHIFT + 1;
    localparam int DIV_STEPS = GAIN_BITS;
    localparam int ITER_BITS = $clog2(DIV_STEPS + 1);
    localparam logic [GAIN_BITS-1:0] GAIN_ONE = GAIN_BITS'(1) << Q_SHIFT;
    localparam logic [Q_SHIFT-1:0]   ROUND_ADD = '1;

    typedef struct packed {
        logic [THR_BITS-1:0] gate_threshold;
        logic [MS_BITS-1:0]  attack_ms;
        logic [MS_BITS-1:0]  hold_ms;
        logic [MS_BITS-1:0]  decay_ms;
        logic [SPM_BITS-1:0] samples_per_ms;
    } cfg_t;

    // micro-operations
    typedef enum logic [2:0] {
        UOP_NOP,
        UOP_WAIT_IN,
        UOP_UPDATE,
        UOP_DIV_INIT,
        UOP_DIV_STEP,
        UOP_MUL,
        UOP_SCALE,
        UOP_EMIT
    } uop_t;

    // jump conditions
    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_IN_VALID,
        COND_FLAT,
        COND_DIV_LAST,
        COND_OUT_FREE
    } cond_t;

    localparam int STEP_BITS = 3;

    localparam logic [STEP_BITS-1:0] ST_WAIT     = 3'd0;
    localparam logic [STEP_BITS-1:0] ST_UPDATE   = 3'd1;
    localparam logic [STEP_BITS-1:0] ST_DIV_INIT = 3'd2;
    localparam logic [STEP_BITS-1:0] ST_DIV_STEP = 3'd3;
    localparam logic [STEP_BITS-1:0] ST_MUL      = 3'd4;
    localparam logic [STEP_BITS-1:0] ST_SCALE    = 3'd5;
    localparam logic [STEP_BITS-1:0] ST_EMIT     = 3'd6;

    // when cond holds jump to target, else stay (loop) or advance
    typedef struct packed {
        uop_t                 op;
        cond_t                cond;
        logic                 loop;
        logic [STEP_BITS-1:0] target;
    } ucode_t;

    typedef struct packed {
        logic flat;
        logic div_last;
    } dp_status_t;

    typedef struct packed {
        logic in_valid;
        logic out_free;
        logic flat;
        logic div_last;
    } seq_cond_t;

    function automatic ucode_t ucode_rom(input logic [STEP_BITS-1:0] step);
        ucode_t w;
        case (step)
            ST_WAIT:     w = '{UOP_WAIT_IN,  COND_IN_VALID, 1'b1, ST_UPDATE};
            ST_UPDATE:   w = '{UOP_UPDATE,   COND_FLAT,     1'b0, ST_MUL};
            ST_DIV_INIT: w = '{UOP_DIV_INIT, COND_NEVER,    1'b0, ST_WAIT};
            ST_DIV_STEP: w = '{UOP_DIV_STEP, COND_DIV_LAST, 1'b1, ST_MUL};
            ST_MUL:      w = '{UOP_MUL,      COND_NEVER,    1'b0, ST_WAIT};
            ST_SCALE:    w = '{UOP_SCALE,    COND_NEVER,    1'b0, ST_WAIT};
            ST_EMIT:     w = '{UOP_EMIT,     COND_OUT_FREE, 1'b1, ST_WAIT};
            default:     w = '{UOP_NOP,      COND_ALWAYS,   1'b0, ST_WAIT};
        endcase
        return w;
    endfunction

endpackage

// ----- rtl/core/ang_useq.sv -----
// ----------------------------------------------------------------------------
// ang_useq
// Microcode sequencer: step counter, control word table and jump logic.
// ----------------------------------------------------------------------------
module ang_useq (
    input  logic               aclk,
    input  logic               aresetn,
    input  ang_pkg::seq_cond_t cond_in,
    output ang_pkg::ucode_t    uword
);

    logic [ang_pkg::STEP_BITS-1:0] step_reg;
    logic [ang_pkg::STEP_BITS-1:0] step_next;
    logic                          take_jump;

    assign uword = ang_pkg::ucode_rom(step_reg);

    always_comb begin
        case (uword.cond)
            ang_pkg::COND_NEVER:    take_jump = 1'b0;
            ang_pkg::COND_ALWAYS:   take_jump = 1'b1;
            ang_pkg::COND_IN_VALID: take_jump = cond_in.in_valid;
            ang_pkg::COND_FLAT:     take_jump = cond_in.flat;
            ang_pkg::COND_DIV_LAST: take_jump = cond_in.div_last;
            ang_pkg::COND_OUT_FREE: take_jump = cond_in.out_free;
            default:                take_jump = 1'b0;
        endcase
    end

    always_comb begin
        if (take_jump) begin
            step_next = uword.target;
        end else if (uword.loop) begin
            step_next = step_reg;
        end else begin
            step_next = step_reg + ang_pkg::STEP_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= ang_pkg::ST_WAIT;
        end else begin
            step_reg <= step_next;
        end
    end

endmodule

// ----- rtl/core/ang_datapath.sv -----
// ----------------------------------------------------------------------------
// ang_datapath
// Gate state, duration counters, serial ramp divider and gain multiplier,
// each driven by the micro-operation of the current step.
// ----------------------------------------------------------------------------
module ang_datapath #(
    parameter int SAMPLE_BITS = 16,
    parameter int COUNT_BITS  = 20
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  ang_pkg::ucode_t               uword,
    input  ang_pkg::cfg_t                 cfg,
    input  logic                          s_accept,
    input  logic signed [SAMPLE_BITS-1:0] s_sample_in,
    output ang_pkg::dp_status_t           status,
    output logic signed [SAMPLE_BITS-1:0] y_out,
    output logic [1:0]                    phase_out
);

    localparam int SB     = SAMPLE_BITS;
    localparam int CB     = COUNT_BITS;
    localparam int GW     = ang_pkg::GAIN_BITS;
    localparam int PROD_W = GW + SB;
    localparam int LP_W   = ang_pkg::LOAD_BITS;
    localparam int LW     = (CB > LP_W) ? CB : LP_W;
    localparam int CMPW   = (SB > ang_pkg::THR_BITS) ? SB : ang_pkg::THR_BITS;
    localparam int IW     = ang_pkg::ITER_BITS;

    localparam logic [CB-1:0] CMAX = '1;

    logic [1:0]        phase_reg, phase_next;
    logic [CB-1:0]     ac_reg, ac_next;
    logic [CB-1:0]     al_reg, al_next;
    logic [CB-1:0]     hc_reg, hc_next;
    logic [CB-1:0]     dc_reg, dc_next;
    logic [CB-1:0]     dl_reg, dl_next;

    logic [SB-1:0]     mag_reg, mag_next;
    logic              neg_reg, neg_next;
    logic [CB-1:0]     num_reg, num_next;
    logic [CB-1:0]     len_reg, len_next;
    logic [CB:0]       rem_reg, rem_next;
    logic [GW-1:0]     q_reg, q_next;
    logic              lz_reg, lz_next;
    logic [IW-1:0]     iter_reg, iter_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [SB-1:0]     y_reg, y_next;

    logic [SB-1:0]     raw_in;
    logic [SB-1:0]     mag_in;
    logic              loud;
    logic [ang_pkg::MS_BITS-1:0] ms_sel;
    logic [LP_W-1:0]   load_prod;
    logic [CB-1:0]     load_len;
    logic [CB-1:0]     ac_dec, dc_dec;
    logic [CB-1:0]     num_clamp;
    logic [CB:0]       rem_sh;
    logic              rem_ge;
    logic [GW-1:0]     gain;
    logic [PROD_W-1:0] prod_rnd;
    logic [SB-1:0]     mag_out;

    // sample magnitude, most negative value maps to 2^(SB-1)
    assign raw_in = s_sample_in;
    assign mag_in = raw_in[SB-1] ? (~raw_in + SB'(1)) : raw_in;

    assign loud = CMPW'(mag_reg) > CMPW'(cfg.gate_threshold);

    // one shared ms * samples_per_ms product, picked by phase and loudness
    always_comb begin
        case (phase_reg)
            ang_pkg::PH_ATTACK: ms_sel = cfg.hold_ms;
            ang_pkg::PH_ACTIVE: ms_sel = loud ? cfg.hold_ms : cfg.decay_ms;
            default:            ms_sel = cfg.attack_ms;
        endcase
    end

    assign load_prod = LP_W'(ms_sel) * LP_W'(cfg.samples_per_ms);
    assign load_len  = (LW'(load_prod) > LW'(CMAX)) ? CMAX : CB'(load_prod);

    assign ac_dec = (ac_reg == '0) ? '0 : ac_reg - CB'(1);
    assign dc_dec = (dc_reg == '0) ? '0 : dc_reg - CB'(1);

    // restoring divider, the first step works on the unshifted numerator
    assign num_clamp = (num_reg > len_reg) ? len_reg : num_reg;
    assign rem_sh    = (iter_reg == IW'(ang_pkg::DIV_STEPS)) ? rem_reg
                                                             : {rem_reg[CB-1:0], 1'b0};
    assign rem_ge    = rem_sh >= {1'b0, len_reg};

    assign gain     = lz_reg ? '0 : q_reg;
    assign prod_rnd = neg_reg ? prod_reg + PROD_W'(ang_pkg::ROUND_ADD) : prod_reg;
    assign mag_out  = prod_rnd[ang_pkg::Q_SHIFT +: SB];

    always_comb begin
        phase_next = phase_reg;
        ac_next    = ac_reg;
        al_next    = al_reg;
        hc_next    = hc_reg;
        dc_next    = dc_reg;
        dl_next    = dl_reg;
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        num_next   = num_reg;
        len_next   = len_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        lz_next    = lz_reg;
        iter_next  = iter_reg;
        prod_next  = prod_reg;
        y_next     = y_reg;

        if (s_accept) begin
            mag_next = mag_in;
            neg_next = raw_in[SB-1];
        end

        case (uword.op)
            ang_pkg::UOP_UPDATE: begin
                case (phase_reg)
                    ang_pkg::PH_IDLE: begin
                        if (loud) begin
                            ac_next    = load_len;
                            al_next    = load_len;
                            phase_next = ang_pkg::PH_ATTACK;
                        end
                        q_next  = '0;
                        lz_next = 1'b0;
                    end
                    ang_pkg::PH_ATTACK: begin
                        if (ac_reg <= CB'(1)) begin
                            hc_next    = load_len;
                            phase_next = ang_pkg::PH_ACTIVE;
                        end
                        ac_next  = ac_dec;
                        num_next = al_reg - ((ac_dec > al_reg) ? al_reg : ac_dec);
                        len_next = al_reg;
                    end
                    ang_pkg::PH_ACTIVE: begin
                        if (loud) begin
                            hc_next = load_len;
                        end else if (hc_reg <= CB'(1)) begin
                            dc_next    = load_len;
                            dl_next    = load_len;
                            phase_next = ang_pkg::PH_DECAY;
                        end else begin
                            hc_next = hc_reg - CB'(1);
                        end
                        q_next  = ang_pkg::GAIN_ONE;
                        lz_next = 1'b0;
                    end
                    default: begin
                        // loud sample restarts attack but still uses decay gain
                        if (loud) begin
                            ac_next    = load_len;
                            al_next    = load_len;
                            phase_next = ang_pkg::PH_ATTACK;
                        end else if (dc_reg <= CB'(1)) begin
                            phase_next = ang_pkg::PH_IDLE;
                        end
                        dc_next  = dc_dec;
                        num_next = dc_dec;
                        len_next = dl_reg;
                    end
                endcase
            end
            ang_pkg::UOP_DIV_INIT: begin
                rem_next  = {1'b0, num_clamp};
                q_next    = '0;
                lz_next   = (len_reg == '0);
                iter_next = IW'(ang_pkg::DIV_STEPS);
            end
            ang_pkg::UOP_DIV_STEP: begin
                rem_next  = rem_ge ? rem_sh - {1'b0, len_reg} : rem_sh;
                q_next    = {q_reg[GW-2:0], rem_ge};
                iter_next = iter_reg - IW'(1);
            end
            ang_pkg::UOP_MUL: begin
                prod_next = PROD_W'(gain) * PROD_W'(mag_reg);
            end
            ang_pkg::UOP_SCALE: begin
                y_next = neg_reg ? (~mag_out + SB'(1)) : mag_out;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= ang_pkg::PH_IDLE;
            ac_reg    <= '0;
            al_reg    <= '0;
            hc_reg    <= '0;
            dc_reg    <= '0;
            dl_reg    <= '0;
            iter_reg  <= '0;
        end else begin
            phase_reg <= phase_next;
            ac_reg    <= ac_next;
            al_reg    <= al_next;
            hc_reg    <= hc_next;
            dc_reg    <= dc_next;
            dl_reg    <= dl_next;
            iter_reg  <= iter_next;
        end
    end

    always_ff @(posedge aclk) begin
        mag_reg  <= mag_next;
        neg_reg  <= neg_next;
        num_reg  <= num_next;
        len_reg  <= len_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        lz_reg   <= lz_next;
        prod_reg <= prod_next;
        y_reg    <= y_next;
    end

    assign status.flat     = (phase_reg == ang_pkg::PH_IDLE) ||
                             (phase_reg == ang_pkg::PH_ACTIVE);
    assign status.div_last = (iter_reg == IW'(1));
    assign y_out           = y_reg;
    assign phase_out       = phase_reg;

endmodule

// ----- rtl/core/audio_noise_gate_top.sv -----
// ----------------------------------------------------------------------------
// audio_noise_gate_top
// In attack and decay a 17-step serial divider forms the ramp gain for each
// input beat; in idle and active the update goes straight to the multiply.
// One sample is in flight at a time; a new sample is taken while the
// previous result waits in the output register.
// Reset (aresetn, synchronous): registers to defaults, gate idle, counters 0.
// ----------------------------------------------------------------------------
module audio_noise_gate_top #(
    parameter int SAMPLE_BITS = 16,
    parameter int COUNT_BITS  = 20
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,

    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [ang_pkg::CFG_IDX_BITS-1:0]        cfg_index,
    input  logic [ang_pkg::CFG_DATA_BITS-1:0]       cfg_data,

    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic signed [SAMPLE_BITS-1:0]           s_sample_in,

    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic signed [SAMPLE_BITS-1:0]           m_sample_out,
    output logic [1:0]                              m_gate_phase
);

    ang_pkg::cfg_t      cfg_reg, cfg_next;
    ang_pkg::ucode_t    uword;
    ang_pkg::dp_status_t dp_status;
    ang_pkg::seq_cond_t seq_cond;

    logic                          s_accept;
    logic                          out_free;
    logic                          emit;
    logic signed [SAMPLE_BITS-1:0] y_val;
    logic [1:0]                    phase_val;

    logic                          m_valid_reg, m_valid_next;
    logic signed [SAMPLE_BITS-1:0] m_sample_reg, m_sample_next;
    logic [1:0]                    m_phase_reg, m_phase_next;

    logic [ang_pkg::MS_BITS-1:0]   ms_wr;
    logic [ang_pkg::SPM_BITS-1:0]  spm_wr;

    // register file, zero durations and samples_per_ms stored as one
    assign cfg_ready = 1'b1;
    assign ms_wr     = (cfg_data[ang_pkg::MS_BITS-1:0] == '0) ? ang_pkg::MS_BITS'(1)
                                                             : cfg_data[ang_pkg::MS_BITS-1:0];
    assign spm_wr    = (cfg_data[ang_pkg::SPM_BITS-1:0] == '0) ? ang_pkg::SPM_BITS'(1)
                                                               : cfg_data[ang_pkg::SPM_BITS-1:0];

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                ang_pkg::REG_THRESHOLD:
                    cfg_next.gate_threshold = cfg_data[ang_pkg::THR_BITS-1:0];
                ang_pkg::REG_ATTACK_MS: cfg_next.attack_ms      = ms_wr;
                ang_pkg::REG_HOLD_MS:   cfg_next.hold_ms        = ms_wr;
                ang_pkg::REG_DECAY_MS:  cfg_next.decay_ms       = ms_wr;
                ang_pkg::REG_SPM:       cfg_next.samples_per_ms = spm_wr;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gate_threshold <= ang_pkg::THRESHOLD_RST;
            cfg_reg.attack_ms      <= ang_pkg::ATTACK_MS_RST;
            cfg_reg.hold_ms        <= ang_pkg::HOLD_MS_RST;
            cfg_reg.decay_ms       <= ang_pkg::DECAY_MS_RST;
            cfg_reg.samples_per_ms <= ang_pkg::SPM_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // input and output beats
    assign s_ready  = (uword.op == ang_pkg::UOP_WAIT_IN);
    assign s_accept = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign emit     = (uword.op == ang_pkg::UOP_EMIT) && out_free;

    assign seq_cond.in_valid = s_valid;
    assign seq_cond.out_free = out_free;
    assign seq_cond.flat     = dp_status.flat;
    assign seq_cond.div_last = dp_status.div_last;

    ang_useq u_useq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cond_in (seq_cond),
        .uword   (uword)
    );

    ang_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .uword       (uword),
        .cfg         (cfg_reg),
        .s_accept    (s_accept),
        .s_sample_in (s_sample_in),
        .status      (dp_status),
        .y_out       (y_val),
        .phase_out   (phase_val)
    );

    always_comb begin
        m_valid_next  = m_valid_reg;
        m_sample_next = m_sample_reg;
        m_phase_next  = m_phase_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (emit) begin
            m_valid_next  = 1'b1;
            m_sample_next = y_val;
            m_phase_next  = phase_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_sample_reg <= m_sample_next;
        m_phase_reg  <= m_phase_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_sample_out = m_sample_reg;
    assign m_gate_phase = m_phase_reg;

endmodule

// ----- rtl/core/ang_checker.sv -----
// ----------------------------------------------------------------------------
// ang_checker
// Port-level checks on the noise gate, attached to the top level by bind.
// ----------------------------------------------------------------------------
module ang_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic signed [SAMPLE_BITS-1:0] m_sample_out,
    input logic [1:0]                    m_gate_phase
);

    // a result beat that waits keeps its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_sample_out) && $stable(m_gate_phase))
        else $error("result changed while stalled");

    // one sample in flight: no input beat right after an input beat
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken on consecutive cycles");

    // a closed gate outputs silence
    a_idle_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_gate_phase == ang_pkg::PH_IDLE) |-> (m_sample_out == '0))
        else $error("nonzero sample with gate idle");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind audio_noise_gate_top ang_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_ang_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_sample_out (m_sample_out),
    .m_gate_phase (m_gate_phase)
);

// ----- tb/sv/gate_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gate_checker
// Watches the register, sample and result channels of the noise gate. Keeps
// its own copy of the registers, gate phase, counters and ramp lengths, works
// out the gated sample and phase for every sample beat, and compares each
// result beat in order. Mismatches are counted for the testbench top.
// ----------------------------------------------------------------------------
module gate_checker #(
    parameter int SAMPLE_BITS = 16,
    parameter int COUNT_BITS  = 20
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    input  logic                                 cfg_valid,
    input  logic                                 cfg_ready,
    input  logic [ang_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [ang_pkg::CFG_DATA_BITS-1:0]    cfg_data,

    input  logic                                 s_valid,
    input  logic                                 s_ready,
    input  logic signed [SAMPLE_BITS-1:0]        s_sample_in,

    input  logic                                 m_valid,
    input  logic                                 m_ready,
    input  logic signed [SAMPLE_BITS-1:0]        m_sample_out,
    input  logic [1:0]                           m_gate_phase,

    output int unsigned                          pending,
    output int unsigned                          mismatches
);

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] pcm;
        logic [1:0]                    state;
    } gated_t;

    localparam longint unsigned CNT_MAX = (64'd1 << COUNT_BITS) - 64'd1;

    logic [ang_pkg::THR_BITS-1:0] thr;
    logic [ang_pkg::MS_BITS-1:0]  atk_ms;
    logic [ang_pkg::MS_BITS-1:0]  hold_ms;
    logic [ang_pkg::MS_BITS-1:0]  dec_ms;
    logic [ang_pkg::SPM_BITS-1:0] spm;

    logic [1:0]            gph;
    logic [COUNT_BITS-1:0] atk_cnt;
    logic [COUNT_BITS-1:0] atk_len;
    logic [COUNT_BITS-1:0] hold_cnt;
    logic [COUNT_BITS-1:0] dec_cnt;
    logic [COUNT_BITS-1:0] dec_len;

    gated_t gated_q[$];
    gated_t want;

    function automatic logic [ang_pkg::MS_BITS-1:0] ms_floor(
        input logic [ang_pkg::MS_BITS-1:0] v);
        return (v == 0) ? ang_pkg::MS_BITS'(1) : v;
    endfunction

    // ms times samples per ms, saturated to the counter width
    function automatic logic [COUNT_BITS-1:0] ramp_len(input longint unsigned ms);
        longint unsigned p;
        p = ms * spm;
        return (p > CNT_MAX) ? COUNT_BITS'(CNT_MAX) : p[COUNT_BITS-1:0];
    endfunction

    function automatic logic [COUNT_BITS-1:0] count_down(input logic [COUNT_BITS-1:0] c);
        return (c == 0) ? c : c - 1'b1;
    endfunction

    // q16 gain, unity at num == len
    function automatic longint unsigned ramp_gain(input longint unsigned num,
                                                  input longint unsigned len);
        if (len == 0)
            return 0;
        if (num > len)
            num = len;
        return (num << ang_pkg::Q_SHIFT) / len;
    endfunction

    // floor of gain * s / 2^16
    function automatic longint apply_gain(input longint unsigned g, input longint s);
        longint          mag;
        longint unsigned prod;
        mag  = (s < 0) ? -s : s;
        prod = g * longint'(mag);
        if (s < 0)
            return -longint'((prod + ang_pkg::ROUND_ADD) >> ang_pkg::Q_SHIFT);
        return longint'(prod >> ang_pkg::Q_SHIFT);
    endfunction

    function automatic gated_t gate_step(input logic signed [SAMPLE_BITS-1:0] x);
        gated_t r;
        longint s;
        longint y;
        longint mag;
        logic   loud;
        s    = x;
        mag  = (s < 0) ? -s : s;
        loud = mag > longint'(thr);
        y    = 0;
        case (gph)
            ang_pkg::PH_IDLE: begin
                if (loud) begin
                    atk_cnt = ramp_len(atk_ms);
                    atk_len = atk_cnt;
                    gph     = ang_pkg::PH_ATTACK;
                end
            end
            ang_pkg::PH_ATTACK: begin
                if (atk_cnt <= 1) begin
                    hold_cnt = ramp_len(hold_ms);
                    gph      = ang_pkg::PH_ACTIVE;
                end
                atk_cnt = count_down(atk_cnt);
                y = apply_gain(ramp_gain(atk_len - ((atk_cnt > atk_len) ? atk_len : atk_cnt),
                                         atk_len), s);
            end
            ang_pkg::PH_ACTIVE: begin
                if (loud) begin
                    hold_cnt = ramp_len(hold_ms);
                end else if (hold_cnt <= 1) begin
                    dec_cnt = ramp_len(dec_ms);
                    dec_len = dec_cnt;
                    gph     = ang_pkg::PH_DECAY;
                end else begin
                    hold_cnt = hold_cnt - 1'b1;
                end
                y = s;
            end
            default: begin
                // a loud sample restarts the attack but is still scaled by the decay gain
                if (loud) begin
                    atk_cnt = ramp_len(atk_ms);
                    atk_len = atk_cnt;
                    gph     = ang_pkg::PH_ATTACK;
                end else if (dec_cnt <= 1) begin
                    gph = ang_pkg::PH_IDLE;
                end
                dec_cnt = count_down(dec_cnt);
                y = apply_gain(ramp_gain(dec_cnt, dec_len), s);
            end
        endcase
        r.pcm   = y[SAMPLE_BITS-1:0];
        r.state = gph;
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input longint got, input longint exp_v);
        $display("%0t gate_checker: %s got %0d, expected %0d", $time, what, got, exp_v);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            thr      = ang_pkg::THRESHOLD_RST;
            atk_ms   = ang_pkg::ATTACK_MS_RST;
            hold_ms  = ang_pkg::HOLD_MS_RST;
            dec_ms   = ang_pkg::DECAY_MS_RST;
            spm      = ang_pkg::SPM_RST;
            gph      = ang_pkg::PH_IDLE;
            atk_cnt  = '0;
            atk_len  = '0;
            hold_cnt = '0;
            dec_cnt  = '0;
            dec_len  = '0;
            gated_q.delete();
            mismatches = 0;
            pending <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    ang_pkg::REG_THRESHOLD: thr = cfg_data[ang_pkg::THR_BITS-1:0];
                    ang_pkg::REG_ATTACK_MS: atk_ms = ms_floor(cfg_data[ang_pkg::MS_BITS-1:0]);
                    ang_pkg::REG_HOLD_MS:   hold_ms = ms_floor(cfg_data[ang_pkg::MS_BITS-1:0]);
                    ang_pkg::REG_DECAY_MS:  dec_ms = ms_floor(cfg_data[ang_pkg::MS_BITS-1:0]);
                    ang_pkg::REG_SPM: begin
                        spm = (cfg_data[ang_pkg::SPM_BITS-1:0] == 0)
                            ? ang_pkg::SPM_BITS'(1) : cfg_data[ang_pkg::SPM_BITS-1:0];
                    end
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (gated_q.size() == 0) begin
                    flag_mismatch("result beat with nothing pending", m_sample_out, 0);
                end else begin
                    want = gated_q.pop_front();
                    if (m_sample_out !== want.pcm)
                        flag_mismatch("sample_out", m_sample_out, want.pcm);
                    if (m_gate_phase !== want.state)
                        flag_mismatch("gate_phase", m_gate_phase, want.state);
                end
            end
            if (s_valid && s_ready)
                gated_q.push_back(gate_step(s_sample_in));
            pending <= gated_q.size();
        end
    end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the noise gate with directed sample sequences through every gate
// phase, then with runs of loud and quiet samples under a series of register
// settings, with random sender bursts and receiver stalls. The checker beside
// the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;

    localparam int          SAMPLE_BITS  = 16;
    localparam int          COUNT_BITS   = 20;
    localparam int          DRAIN_CYCLES = 40;
    localparam int unsigned CYCLE_LIMIT  = 400000;

    logic                                 aclk = 1'b0;
    logic                                 aresetn;
    logic                                 cfg_valid;
    logic                                 cfg_ready;
    logic [ang_pkg::CFG_IDX_BITS-1:0]     cfg_index;
    logic [ang_pkg::CFG_DATA_BITS-1:0]    cfg_data;
    logic                                 s_valid;
    logic                                 s_ready;
    logic signed [SAMPLE_BITS-1:0]        s_sample_in;
    logic                                 m_valid;
    logic                                 m_ready = 1'b0;
    logic signed [SAMPLE_BITS-1:0]        m_sample_out;
    logic [1:0]                           m_gate_phase;

    int unsigned pending;
    int unsigned mismatches;
    int unsigned cycles = 0;

    // settings as last written, used to shape the loud and quiet runs
    int thr_cur = int'(ang_pkg::THRESHOLD_RST);
    int atk_n   = int'(ang_pkg::ATTACK_MS_RST) * int'(ang_pkg::SPM_RST);
    int hold_n  = int'(ang_pkg::HOLD_MS_RST) * int'(ang_pkg::SPM_RST);
    int dec_n   = int'(ang_pkg::DECAY_MS_RST) * int'(ang_pkg::SPM_RST);

    int burst_left = 0;

    logic [15:0] stall_pat  = '1;
    logic [15:0] stall_next;
    int          stall_age  = 0;

    audio_noise_gate_top #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample_in  (s_sample_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sample_out (m_sample_out),
        .m_gate_phase (m_gate_phase)
    );

    gate_checker #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) chk (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample_in  (s_sample_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sample_out (m_sample_out),
        .m_gate_phase (m_gate_phase),
        .pending      (pending),
        .mismatches   (mismatches)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // receiver: rotating ready pattern, reloaded now and then; bit 0 always set
    // so every pattern holds a ready bit and a stall ends within one rotation
    always @(posedge aclk) begin
        stall_next = {stall_pat[0], stall_pat[15:1]};
        if (stall_age == 0) begin
            case ($urandom_range(0, 3))
                0:       stall_next = '1;
                1:       stall_next = 16'($urandom()) | 16'h0001;
                default: stall_next = 16'($urandom() | $urandom()) | 16'h0001;
            endcase
            stall_age <= $urandom_range(30, 300);
        end else begin
            stall_age <= stall_age - 1;
        end
        stall_pat <= stall_next;
        m_ready   <= stall_next[0];
    end

    function automatic int at_least_one(input int v);
        return (v == 0) ? 1 : v;
    endfunction

    // value in the low bits, random junk above the register width
    function automatic logic [ang_pkg::CFG_DATA_BITS-1:0] cfg_word(input int value,
                                                                 input int width);
        logic [ang_pkg::CFG_DATA_BITS-1:0] mask;
        mask = (ang_pkg::CFG_DATA_BITS'(1) << width) - 1'b1;
        return (ang_pkg::CFG_DATA_BITS'($urandom()) & ~mask)
             | (ang_pkg::CFG_DATA_BITS'(value) & mask);
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(input bit loud);
        int mag;
        if (loud)
            mag = $urandom_range(32768, thr_cur + 1);
        else
            mag = $urandom_range(thr_cur, 0);
        if (mag == 32768 || (mag != 0 && $urandom_range(0, 1) == 1))
            return SAMPLE_BITS'(-mag);
        return SAMPLE_BITS'(mag);
    endfunction

    task automatic write_reg(input logic [ang_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [ang_pkg::CFG_DATA_BITS-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic set_regs(input logic [ang_pkg::CFG_DATA_BITS-1:0] thr_d, atk_d, hold_d,
                            dec_d, spm_d);
        int spm_v;
        write_reg(ang_pkg::REG_THRESHOLD, thr_d);
        write_reg(ang_pkg::REG_ATTACK_MS, atk_d);
        write_reg(ang_pkg::REG_HOLD_MS, hold_d);
        write_reg(ang_pkg::REG_DECAY_MS, dec_d);
        write_reg(ang_pkg::REG_SPM, spm_d);
        cfg_valid <= 1'b0;
        spm_v   = at_least_one(int'(spm_d[ang_pkg::SPM_BITS-1:0]));
        thr_cur = int'(thr_d[ang_pkg::THR_BITS-1:0]);
        atk_n   = at_least_one(int'(atk_d[ang_pkg::MS_BITS-1:0])) * spm_v;
        hold_n  = at_least_one(int'(hold_d[ang_pkg::MS_BITS-1:0])) * spm_v;
        dec_n   = at_least_one(int'(dec_d[ang_pkg::MS_BITS-1:0])) * spm_v;
    endtask

    // sender: bursts of random length, random gaps in between
    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] v);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
            gap = $urandom_range(0, 10);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid     <= 1'b1;
        s_sample_in <= v;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic wait_drained();
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // alternating loud and quiet runs sized to the counters, with noise mixed in
    task automatic run_gate_traffic(input int n);
        int sent;
        int span;
        int run;
        bit loud;
        sent = 0;
        loud = 1'b1;
        while (sent < n) begin
            if ($urandom_range(0, 5) == 0) begin
                run = $urandom_range(1, 6);
                repeat (run) send_sample(SAMPLE_BITS'($urandom()));
            end else begin
                span = loud ? atk_n + hold_n + 2 : hold_n + dec_n + 3;
                if (span > 40)
                    span = 40;
                run = $urandom_range(1, span);
                repeat (run) send_sample(pick_sample(loud));
            end
            sent += run;
            loud = !loud;
        end
        s_valid <= 1'b0;
    endtask

    initial begin
        logic signed [SAMPLE_BITS-1:0] warm[10];
        // unit-length counters: open, pass, close, retrigger out of decay, fall idle
        logic signed [SAMPLE_BITS-1:0] walk[14];
        int thr_v;
        int atk_v;
        int hold_v;
        int dec_v;
        int spm_v;
        int n;

        warm = '{16'sd0, 16'sd1000, -16'sd1000, -16'sd1001, 16'sd32767, 16'sh8000,
                 -16'sd1, 16'sd1, 16'sh5555, -16'sd21846};
        walk = '{16'sd50, -16'sd100, 16'sd101, 16'sd7, -16'sd100, 16'sd32767,
                 16'sh8000, 16'sh8000, 16'sd0, 16'sd0, -16'sd101, 16'sd3, 16'sd3,
                 16'sd3};

        aresetn     <= 1'b0;
        cfg_valid   <= 1'b0;
        cfg_index   <= '0;
        cfg_data    <= '0;
        s_valid     <= 1'b0;
        s_sample_in <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: threshold edges, then into a long attack ramp
        foreach (warm[i]) send_sample(warm[i]);
        s_valid <= 1'b0;
        wait_drained();

        // zero durations masked in from junk upper bits, threshold 100
        set_regs(16'h8064, 16'hF800, 16'hF800, 16'hF800, 16'hFF00);
        @(posedge aclk);
        for (int i = ang_pkg::REG_SPM + 1; i < 2 ** ang_pkg::CFG_IDX_BITS; i++)
            write_reg(ang_pkg::CFG_IDX_BITS'(i), ang_pkg::CFG_DATA_BITS'($urandom()));
        cfg_valid <= 1'b0;
        @(posedge aclk);
        foreach (walk[i]) send_sample(walk[i]);
        s_valid <= 1'b0;
        wait_drained();

        for (int p = 0; p < 10; p++) begin
            case (p)
                0: begin
                    thr_v = $urandom_range(0, 3000);
                    atk_v = $urandom_range(1, 4);
                    hold_v = $urandom_range(1, 4);
                    dec_v = $urandom_range(1, 4);
                    spm_v = $urandom_range(1, 3);
                    n = 80;
                end
                1: begin
                    thr_v = 0;
                    atk_v = $urandom_range(0, 3);
                    hold_v = $urandom_range(0, 3);
                    dec_v = $urandom_range(0, 3);
                    spm_v = 2;
                    n = 75;
                end
                2: begin
                    // only the most negative sample gets past this threshold
                    thr_v = 32767;
                    atk_v = $urandom_range(1, 3);
                    hold_v = $urandom_range(1, 3);
                    dec_v = $urandom_range(1, 3);
                    spm_v = 1;
                    n = 60;
                end
                3: begin
                    thr_v = $urandom_range(0, 2000);
                    atk_v = 1;
                    hold_v = 1;
                    dec_v = 1;
                    spm_v = 255;
                    n = 40;
                end
                4: begin
                    thr_v = $urandom_range(0, 2000);
                    atk_v = 2047;
                    hold_v = 2047;
                    dec_v = 2047;
                    spm_v = 1;
                    n = 40;
                end
                default: begin
                    thr_v = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 4000)
                                                        : $urandom_range(0, 32767);
                    atk_v = $urandom_range(0, 6);
                    hold_v = $urandom_range(0, 6);
                    dec_v = $urandom_range(0, 6);
                    spm_v = $urandom_range(0, 4);
                    n = 75;
                end
            endcase
            set_regs(cfg_word(thr_v, ang_pkg::THR_BITS), cfg_word(atk_v, ang_pkg::MS_BITS),
                     cfg_word(hold_v, ang_pkg::MS_BITS), cfg_word(dec_v, ang_pkg::MS_BITS),
                     cfg_word(spm_v, ang_pkg::SPM_BITS));
            @(posedge aclk);
            run_gate_traffic(n);
            wait_drained();
        end

        if (mismatches == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
